[rtl/core/kmrp_pkg.sv]
// Shared types and constants for the key macro record/playback unit.
// No dependencies.
`timescale 1ns / 1ps
package kmrp_pkg;
  localparam int unsigned CodeW = 10;
  localparam int unsigned StateW = 2;
  localparam int unsigned EventW = CodeW + StateW;
  localparam logic [CodeW-1:0] CodeLctrl = 10'd29;
  localparam logic [CodeW-1:0] CodeLalt = 10'd56;
  localparam logic [CodeW-1:0] CodeLshift = 10'd42;
  localparam logic [StateW-1:0] StRelease = 2'd0;
  localparam logic [StateW-1:0] StPress = 2'd1;

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic [StateW-1:0] key_state;
  } key_item_t;

  typedef struct packed {
    logic [CodeW-1:0] play_code;
    logic [StateW-1:0] play_state;
    logic sync_point;
    logic last_of_run;
  } play_item_t;

  // Classification of the held-key table after one event.
  typedef struct packed {
    logic idle;
    logic chord;
    logic slot_hit;
    logic [3:0] slot;
  } class_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic track;
    logic arm_set;
    logic arm_clr;
    logic rec_start;
    logic rec_stop;
    logic store;
    logic pend_set;
    logic play_start;
    logic play_step;
  } dp_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    class_t cls;
    logic armed;
    logic recording;
    logic pending;
    logic play_empty;
    logic play_last;
  } dp_stat_t;
endpackage

[rtl/core/kmrp_if.sv]
// Valid/ready channel interface used by the key macro unit.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface kmrp_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/core/kmrp_datapath.sv]
// Datapath: held-key table, slot tags, lengths, event memory, playback pointer.
// Depends on kmrp_pkg.
`timescale 1ns / 1ps
module kmrp_datapath #(
  parameter int unsigned MacroDepth = 64,
  parameter int unsigned SlotCount = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  kmrp_pkg::key_item_t item_i,
  input  kmrp_pkg::dp_cmd_t cmd_i,
  output kmrp_pkg::dp_stat_t stat_o,
  output kmrp_pkg::play_item_t play_o
);
  import kmrp_pkg::*;

  localparam int unsigned IdxW = $clog2(MacroDepth);
  localparam int unsigned LenW = $clog2(MacroDepth + 1);
  localparam int unsigned SlotW = 4;
  localparam int unsigned MemDepth = SlotCount * MacroDepth;
  localparam int unsigned AddrW = $clog2(MemDepth);
  localparam logic [SlotW-1:0] NoSlot = 4'd15;

  logic [CodeW-1:0] held_code_q [3];
  logic [2:0] held_valid_q;
  logic [CodeW-1:0] tag_q [SlotCount][3];
  logic [LenW-1:0] len_q [SlotCount];
  logic [SlotW-1:0] rec_slot_q, pend_q, play_slot_q;
  logic armed_q, rec_q;
  logic [IdxW-1:0] ptr_q;
  logic [LenW-1:0] play_len_q;
  logic signed [LenW+1:0] bal_q;
  logic [EventW-1:0] mem [MemDepth];
  logic [EventW-1:0] rd_q;

  // Held table after tracking the current event (combinational look-ahead).
  logic [CodeW-1:0] hc [3];
  logic [2:0] hv;
  logic done;
  always_comb begin
    hc = held_code_q;
    hv = held_valid_q;
    done = 1'b0;
    if (item_i.key_state == StPress) begin
      for (int k = 0; k < 3; k++) begin
        if (!done && !held_valid_q[k]) begin
          hv[k] = 1'b1;
          hc[k] = item_i.key_code;
          done = 1'b1;
        end
      end
    end else if (item_i.key_state == StRelease) begin
      for (int k = 0; k < 3; k++) begin
        if (!done && held_valid_q[k] && held_code_q[k] == item_i.key_code) begin
          hv[k] = 1'b0;
          done = 1'b1;
        end
      end
    end
  end

  class_t cls;
  logic [1:0] n_mod;
  logic [1:0] n_slot;
  logic found;
  always_comb begin
    cls = '0;
    n_mod = '0;
    found = 1'b0;
    n_slot = '0;
    cls.idle = (hv == 3'b000);
    for (int k = 0; k < 3; k++) begin
      if (hv[k] && (hc[k] == CodeLctrl || hc[k] == CodeLalt || hc[k] == CodeLshift)) begin
        n_mod = n_mod + 2'd1;
      end
    end
    cls.chord = (n_mod == 2'd3);
    for (int s = 0; s < SlotCount; s++) begin
      n_slot = '0;
      for (int k = 0; k < 3; k++) begin
        if (hv[k] && (hc[k] == tag_q[s][0] || hc[k] == tag_q[s][1] ||
                      hc[k] == tag_q[s][2])) begin
          n_slot = n_slot + 2'd1;
        end
      end
      if (!found && n_slot == 2'd3) begin
        found = 1'b1;
        cls.slot = SlotW'(s);
      end
    end
    cls.slot_hit = found && !cls.chord && !cls.idle;
  end

  logic [SlotW-1:0] next_slot;
  assign next_slot = (rec_slot_q == SlotW'(SlotCount - 1)) ? '0 : rec_slot_q + 1'b1;

  logic [LenW-1:0] rec_len;
  assign rec_len = len_q[rec_slot_q];

  // A store is dropped once the slot is full.
  logic wr_en;
  logic [EventW-1:0] wr_data;
  assign wr_en = cmd_i.store && (rec_len < LenW'(MacroDepth));
  assign wr_data = {item_i.key_code, item_i.key_state};

  // Reads the pointer entry, the next on a step, or a pending slot's first on a start.
  logic [AddrW-1:0] wr_addr, rd_addr;
  assign wr_addr = AddrW'(rec_slot_q * MacroDepth) + AddrW'(rec_len);
  assign rd_addr = cmd_i.play_start ? AddrW'(pend_q * MacroDepth)
                 : AddrW'(play_slot_q * MacroDepth) + AddrW'(ptr_q)
                   + (cmd_i.play_step ? AddrW'(1) : AddrW'(0));

  // A store to the address being read in the same cycle is forwarded to the read register.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == rd_addr) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // Length of the slot to play, counting an event stored in the same cycle.
  logic [LenW-1:0] play_len_n;
  always_comb begin
    play_len_n = '0;
    if (pend_q < SlotW'(SlotCount)) begin
      if (wr_en && pend_q == rec_slot_q) begin
        play_len_n = rec_len + LenW'(1);
      end else begin
        play_len_n = len_q[pend_q[SlotW-1:0]];
      end
    end
  end

  logic signed [LenW+1:0] bal_n;
  assign bal_n = bal_q + ((rd_q[StateW-1:0] != StRelease) ? (LenW+2)'(1) : -(LenW+2)'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= '0;
      for (int k = 0; k < 3; k++) held_code_q[k] <= '0;
      for (int s = 0; s < SlotCount; s++) begin
        len_q[s] <= '0;
        for (int k = 0; k < 3; k++) tag_q[s][k] <= '0;
      end
      rec_slot_q <= '0;
      pend_q <= NoSlot;
      play_slot_q <= '0;
      armed_q <= 1'b0;
      rec_q <= 1'b0;
      ptr_q <= '0;
      play_len_q <= '0;
      bal_q <= '0;
    end else begin
      if (cmd_i.track) begin
        held_valid_q <= hv;
        held_code_q <= hc;
      end
      if (cmd_i.arm_set) armed_q <= 1'b1;
      if (cmd_i.arm_clr) armed_q <= 1'b0;
      if (cmd_i.rec_start) begin
        rec_q <= 1'b1;
        len_q[rec_slot_q] <= '0;
      end
      if (cmd_i.rec_stop) begin
        rec_q <= 1'b0;
        len_q[rec_slot_q] <= (rec_len >= LenW'(2)) ? rec_len - LenW'(2) : '0;
        tag_q[rec_slot_q][0] <= CodeLctrl;
        tag_q[rec_slot_q][1] <= CodeLshift;
        tag_q[rec_slot_q][2] <= (rec_slot_q == '0) ? CodeW'(11) : CodeW'(rec_slot_q) + CodeW'(1);
        rec_slot_q <= next_slot;
      end
      if (wr_en) begin
        len_q[rec_slot_q] <= rec_len + LenW'(1);
      end
      if (cmd_i.pend_set) pend_q <= cls.slot;
      if (cmd_i.play_start) begin
        pend_q <= NoSlot;
        play_slot_q <= pend_q;
        play_len_q <= play_len_n;
        ptr_q <= '0;
        bal_q <= '0;
      end
      if (cmd_i.play_step) begin
        ptr_q <= ptr_q + 1'b1;
        bal_q <= bal_n;
      end
    end
  end

  assign play_o.play_code = rd_q[EventW-1:StateW];
  assign play_o.play_state = rd_q[StateW-1:0];
  assign play_o.sync_point = (bal_n == '0);
  assign play_o.last_of_run = (LenW'(ptr_q) + LenW'(1) == play_len_q);

  assign stat_o.cls = cls;
  assign stat_o.armed = armed_q;
  assign stat_o.recording = rec_q;
  assign stat_o.pending = (pend_q != NoSlot);
  assign stat_o.play_empty = (play_len_q == '0);
  assign stat_o.play_last = play_o.last_of_run;
endmodule

[rtl/core/kmrp_ctrl.sv]
// Controller: decides per event which datapath actions fire, then drives playback.
// Depends on kmrp_pkg.
`timescale 1ns / 1ps
module kmrp_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  kmrp_pkg::dp_stat_t stat_i,
  output kmrp_pkg::dp_cmd_t cmd_o
);
  import kmrp_pkg::*;

  typedef enum logic [1:0] {SIdle, SLoad, SPlay} state_e;
  state_e state_q, state_d;

  logic take;
  assign in_ready_o = (state_q == SIdle);
  assign take = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == SPlay);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (take) begin
          cmd_o.track = 1'b1;
          if (stat_i.cls.chord && stat_i.recording) begin
            cmd_o.rec_stop = 1'b1;
          end else if (stat_i.cls.chord) begin
            cmd_o.arm_set = 1'b1;
          end else if (stat_i.armed && stat_i.cls.idle) begin
            cmd_o.arm_clr = 1'b1;
            cmd_o.rec_start = 1'b1;
          end else begin
            if (stat_i.cls.chord) cmd_o.arm_set = 1'b1;
            cmd_o.store = stat_i.recording;
            cmd_o.pend_set = stat_i.cls.slot_hit;
            if (stat_i.pending && stat_i.cls.idle) begin
              cmd_o.play_start = 1'b1;
              state_d = SLoad;
            end
          end
          if (stat_i.cls.chord && !stat_i.recording) cmd_o.store = 1'b0;
        end
      end
      SLoad: state_d = stat_i.play_empty ? SIdle : SPlay;
      SPlay: begin
        if (out_ready_i) begin
          cmd_o.play_step = 1'b1;
          if (stat_i.play_last) state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end
endmodule

[rtl/core/key_macro_record_playback_unit.sv]
// Key macro record/playback unit, top level.
// A key event is taken while idle; a playback first passes a load state that fetches the
// first stored event, then gives one transfer per cycle while the output is ready.
// Key events are taken one per cycle outside playback; none is taken during a playback.
// Reset: asynchronous, clears held keys, slot tags, lengths and flags; memory is not cleared.
`timescale 1ns / 1ps
module key_macro_record_playback_unit #(
  parameter int unsigned MACRO_DEPTH = 64,
  parameter int unsigned SLOT_COUNT = 10
) (
  input logic clk_i,
  input logic rst_ni,
  kmrp_if.sink key_i,
  kmrp_if.source play_o
);
  import kmrp_pkg::*;

  dp_cmd_t cmd;
  dp_stat_t stat;
  play_item_t play;

  // The controller sequences each event and the playback walk.
  kmrp_ctrl u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(key_i.valid),
    .in_ready_o(key_i.ready),
    .out_valid_o(play_o.valid),
    .out_ready_i(play_o.ready),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  // The datapath holds the tables, memory and pointers; the memory read register is the output stage.
  kmrp_datapath #(
    .MacroDepth(MACRO_DEPTH),
    .SlotCount(SLOT_COUNT)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(key_i.payload),
    .cmd_i(cmd),
    .stat_o(stat),
    .play_o(play)
  );

  assign play_o.payload = play;

  // A new event is never taken while playback output is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_o.valid |-> !key_i.ready) else $error("input taken during playback");
  // A stop never happens unless recording.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rec_stop |-> stat.recording) else $error("stop without recording");
  // A last event ends the playback.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (play_o.valid && play_o.ready && play.last_of_run) |=> !play_o.valid)
    else $error("playback ran past last event");
endmodule
